@@ rtl/core/ctb_pkg.sv @@
// Shared types for the cursor text buffer: character, command codes, control states, stack control.
package ctb_pkg;

    typedef logic [7:0] t_char;

    // Command codes carried in the opcode field
    typedef enum logic [2:0] {
        OP_LEFT   = 3'd0,
        OP_RIGHT  = 3'd1,
        OP_BACK   = 3'd2,
        OP_INSERT = 3'd3,
        OP_READ   = 3'd4
    } t_opcode;

    // Control states of the top level
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_ctb_state;

    // Shift control handed to every cell of one stack
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

@@ rtl/core/ctb_cell.sv @@
// One storage cell of a character stack: takes from the cell above or below.
module ctb_cell
    import ctb_pkg::*;
(
    input  logic       i_clk,
    input  t_stack_ctl i_ctl,
    input  t_char      i_from_top,
    input  t_char      i_from_below,
    output t_char      o_char
);

    t_char r_char;

    // push moves everything one place down, pop one place up
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_char <= i_from_top;
        end else if (i_ctl.pop) begin
            r_char <= i_from_below;
        end
    end

    assign o_char = r_char;

endmodule

@@ rtl/core/ctb_stack.sv @@
// Character stack built as a row of cells; cell 0 is the top of the stack.
module ctb_stack
    import ctb_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  logic       i_clk,
    input  t_stack_ctl i_ctl,
    input  t_char      i_push_char,
    output t_char      o_cells [CAPACITY]
);

    t_char w_cells [CAPACITY];

    // each cell sees its two neighbours; the ends see the pushed word and zero
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_char w_top;
        t_char w_below;

        if (i == 0) begin : g_head
            assign w_top = i_push_char;
        end else begin : g_body
            assign w_top = w_cells[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_below = '0;
        end else begin : g_link
            assign w_below = w_cells[i+1];
        end

        ctb_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_top   (w_top),
            .i_from_below (w_below),
            .o_char       (w_cells[i])
        );

        assign o_cells[i] = w_cells[i];
    end

endmodule

@@ rtl/core/ctb_read_tree.sv @@
// Registered binary select tree that picks one cell of either stack for a read.
module ctb_read_tree
    import ctb_pkg::*;
#(
    parameter int CAPACITY = 4096,
    localparam int IW      = $clog2(CAPACITY),
    localparam int LEAVES  = 2 ** IW
) (
    input  logic          i_clk,
    input  logic          i_sel_before,
    input  logic [IW-1:0] i_idx,
    input  t_char         i_before [CAPACITY],
    input  t_char         i_after  [CAPACITY],
    output t_char         o_char
);

    t_char w_leaf [LEAVES];
    // level k occupies LEAVES - 2**(IW-k+1) onwards; the root is the last node
    t_char r_node [LEAVES-1];

    // leaf choice between the two stacks; padding leaves read as zero
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < CAPACITY) begin : g_used
            assign w_leaf[i] = i_sel_before ? i_before[i] : i_after[i];
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    // one index bit per level, one register level per cycle
    for (genvar k = 1; k <= IW; k++) begin : g_level
        localparam int BASE  = LEAVES - (2 ** (IW - k + 1));
        localparam int COUNT = 2 ** (IW - k);
        for (genvar j = 0; j < COUNT; j++) begin : g_node
            if (k == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_node[BASE+j] <= i_idx[0] ? w_leaf[2*j+1] : w_leaf[2*j];
                end
            end else begin : g_upper
                localparam int PREV = LEAVES - (2 ** (IW - k + 2));
                always_ff @(posedge i_clk) begin
                    r_node[BASE+j] <= i_idx[k-1] ? r_node[PREV+2*j+1]
                                                 : r_node[PREV+2*j];
                end
            end
        end
    end

    assign o_char = r_node[LEAVES-2];

endmodule

@@ rtl/core/cursor_text_buffer.sv @@
// Cursor text buffer: gap buffer held in two shifting cell stacks.
//
// Input channel (i_in_valid / o_in_stall) takes one command word: move left,
// move right, backspace, insert or read. Output channel (o_out_valid /
// i_out_stall) returns one result word per command: cursor, length, read
// data, read hit flag and insert overflow flag.
// Edit and move commands complete at the accepting edge; their result is
// shown from the next cycle, so they run at one command per cycle while
// the receiver keeps up.
// A read that hits the text walks a registered select tree of
// clog2(CAPACITY) levels, and no command is taken until its result
// is loaded.
// A read past the length answers at once with the hit flag low.
// The result register holds its word while i_out_stall is high; a new
// command is taken only when that register is empty or being emptied.
// Reset clears cursor, length, state and the output valid; stack contents
// are not cleared, as no entry is read before it has been written.
module cursor_text_buffer
    import ctb_pkg::*;
#(
    parameter int CAPACITY = 4096,
    localparam int PW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [2:0]    i_opcode,
    input  logic [7:0]    i_new_char,
    input  logic [PW-1:0] i_read_position,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [CW-1:0] o_cursor_now,
    output logic [CW-1:0] o_length_now,
    output logic [7:0]    o_read_char,
    output logic          o_read_valid,
    output logic          o_overflow
);

    localparam int WW = $clog2(PW + 1);
    localparam logic [WW-1:0] TREE_DEPTH = WW'(PW);

    t_ctb_state    r_state, n_state;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_length, n_length;
    logic [WW-1:0] r_wait, n_wait;
    logic          r_sel_before, n_sel_before;
    logic [PW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_char         r_read_char, n_read_char;
    logic          r_read_valid, n_read_valid;
    logic          r_overflow, n_overflow;

    t_stack_ctl    w_b_ctl, w_a_ctl;
    t_char         w_b_push, w_a_push;
    t_char         w_before [CAPACITY];
    t_char         w_after  [CAPACITY];
    t_char         w_tree_char;
    logic          w_in_take;
    logic          w_out_take;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_before_idx;
    logic [CW-1:0] w_after_idx;

    // text left of the cursor, nearest character on top
    ctb_stack #(.CAPACITY(CAPACITY)) u_before (
        .i_clk       (i_clk),
        .i_ctl       (w_b_ctl),
        .i_push_char (w_b_push),
        .o_cells     (w_before)
    );

    // text right of the cursor, nearest character on top
    ctb_stack #(.CAPACITY(CAPACITY)) u_after (
        .i_clk       (i_clk),
        .i_ctl       (w_a_ctl),
        .i_push_char (w_a_push),
        .o_cells     (w_after)
    );

    ctb_read_tree #(.CAPACITY(CAPACITY)) u_tree (
        .i_clk        (i_clk),
        .i_sel_before (r_sel_before),
        .i_idx        (r_idx),
        .i_before     (w_before),
        .i_after      (w_after),
        .o_char       (w_tree_char)
    );

    // handshakes
    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    // read position as a depth into either stack
    assign w_pos        = CW'(i_read_position);
    assign w_before_idx = r_cursor - CW'(1) - w_pos;
    assign w_after_idx  = w_pos - r_cursor;

    // next state and stack control
    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_length     = r_length;
        n_wait       = r_wait;
        n_sel_before = r_sel_before;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !w_out_take;
        n_read_char  = r_read_char;
        n_read_valid = r_read_valid;
        n_overflow   = r_overflow;
        w_b_ctl      = '0;
        w_a_ctl      = '0;
        w_b_push     = i_new_char;
        w_a_push     = w_before[0];

        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_out_valid  = 1'b1;
                    n_read_char  = '0;
                    n_read_valid = 1'b0;
                    n_overflow   = 1'b0;
                    case (t_opcode'(i_opcode))
                        OP_LEFT: begin
                            if (r_cursor != '0) begin
                                w_b_ctl.pop  = 1'b1;
                                w_a_ctl.push = 1'b1;
                                n_cursor     = r_cursor - CW'(1);
                            end
                        end
                        OP_RIGHT: begin
                            if (r_cursor < r_length) begin
                                w_a_ctl.pop  = 1'b1;
                                w_b_ctl.push = 1'b1;
                                w_b_push     = w_after[0];
                                n_cursor     = r_cursor + CW'(1);
                            end
                        end
                        OP_BACK: begin
                            if (r_cursor != '0) begin
                                w_b_ctl.pop = 1'b1;
                                n_cursor    = r_cursor - CW'(1);
                                n_length    = r_length - CW'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (r_length >= CW'(CAPACITY)) begin
                                n_overflow = 1'b1;
                            end else begin
                                w_b_ctl.push = 1'b1;
                                n_cursor     = r_cursor + CW'(1);
                                n_length     = r_length + CW'(1);
                            end
                        end
                        OP_READ: begin
                            if (w_pos < r_length) begin
                                // hit: hold the result back until the tree settles
                                n_out_valid  = 1'b0;
                                n_state      = ST_READ;
                                n_wait       = TREE_DEPTH;
                                n_sel_before = w_pos < r_cursor;
                                n_idx        = (w_pos < r_cursor) ? w_before_idx[PW-1:0]
                                                                  : w_after_idx[PW-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - WW'(1);
                end else begin
                    n_out_valid  = 1'b1;
                    n_read_char  = w_tree_char;
                    n_read_valid = 1'b1;
                    n_overflow   = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_length    <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_length    <= n_length;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    // read request and result payload
    always_ff @(posedge i_clk) begin
        r_sel_before <= n_sel_before;
        r_idx        <= n_idx;
        r_read_char  <= n_read_char;
        r_read_valid <= n_read_valid;
        r_overflow   <= n_overflow;
    end

    // cursor and length are stable while a word waits, so they drive the port
    assign o_out_valid  = r_out_valid;
    assign o_cursor_now = r_cursor;
    assign o_length_now = r_length;
    assign o_read_char  = r_read_char;
    assign o_read_valid = r_read_valid;
    assign o_overflow   = r_overflow;

    // cursor never passes the end of the text
    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_length)
        else $error("cursor beyond text length");

    // length never exceeds the stack depth
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length <= CW'(CAPACITY))
        else $error("text length beyond capacity");

    // overflow is only reported with a full buffer
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_overflow) |-> (r_length == CW'(CAPACITY)))
        else $error("overflow flagged below capacity");

    // a pending read blocks both channels until its result is loaded
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (o_in_stall && !r_out_valid))
        else $error("command or result overlaps a pending read");

    // a read hit leaves the pending state with the hit flag set
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && r_wait == '0) |=> (r_out_valid && r_read_valid))
        else $error("read result lost");

endmodule
